// File: rtl/rgbe_rle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbe_rle_pkg
// Shared widths, constants and status codes of the RGBE scanline decoder.
// ----------------------------------------------------------------------------
package rgbe_rle_pkg;

  localparam int unsigned DEF_MAX_LINE_WIDTH = 8192;
  localparam int unsigned MIN_LINE_WIDTH     = 8;

  localparam int unsigned LW_W   = 14;
  localparam int unsigned IDX_W  = 13;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned ST_W   = 3;
  localparam int unsigned HDR_W  = 24;
  localparam int unsigned CMP_W  = 16;

  localparam logic [LW_W-1:0]   LW_RESET   = LW_W'(MIN_LINE_WIDTH);
  localparam logic [BYTE_W-1:0] HDR_MAGIC  = 8'h02;
  localparam logic [BYTE_W-1:0] RUN_BASE   = 8'h80;

  typedef enum logic [ST_W-1:0] {
    ST_DONE       = 3'd0,
    ST_BAD_HEADER = 3'd1,
    ST_WIDTH      = 3'd2,
    ST_ZERO       = 3'd3,
    ST_OVERRUN    = 3'd4,
    ST_READ       = 3'd5
  } status_e;

endpackage

// File: rtl/rgbe_rle_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbe_rle_if
// Valid/ready channels of the decoder: requests, responses and configuration.
// ----------------------------------------------------------------------------
interface rgbe_rle_req_if;
  import rgbe_rle_pkg::*;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [BYTE_W-1:0] stream_byte;
  logic [IDX_W-1:0]  pixel_index;
  modport source (output valid, req_type, stream_byte, pixel_index, input ready);
  modport sink   (input valid, req_type, stream_byte, pixel_index, output ready);
endinterface

interface rgbe_rle_rsp_if;
  import rgbe_rle_pkg::*;
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [WORD_W-1:0] pixel_word;
  modport source (output valid, status, pixel_word, input ready);
  modport sink   (input valid, status, pixel_word, output ready);
endinterface

interface rgbe_rle_cfg_if;
  import rgbe_rle_pkg::*;
  logic            valid;
  logic            ready;
  logic [LW_W-1:0] line_width;
  modport source (output valid, line_width, input ready);
  modport sink   (input valid, line_width, output ready);
endinterface

// File: rtl/rgbe_rle_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbe_rle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rgbe_rle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/rgbe_scanline_rle_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbe_scanline_rle_decoder_top
// Run-length scanline decoder for RGBE images with a four-bank line store.
// ----------------------------------------------------------------------------
// A run value byte starts a fill that writes the run (count-128, so up to 127
// pixels) into the line store through its single write port, one byte a
// cycle. For a pixel read the four channel banks are read together, and
// their registered data is then put into the holding register. Every result
// goes through a holding register into the output register. Once the result
// sits in the output register a new transaction is taken while it waits on
// the response channel; a second result stays held, and blocks new
// transactions, until the first is taken. The line width register is
// written only while no run fill or read is in progress. The line store is
// not cleared after reset; pixels never written read back as unknown data.
module rgbe_scanline_rle_decoder_top #(
  parameter int unsigned MAX_LINE_WIDTH = rgbe_rle_pkg::DEF_MAX_LINE_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rgbe_rle_req_if.sink          req_i,
  rgbe_rle_rsp_if.source        rsp_o,
  rgbe_rle_cfg_if.sink          cfg_i
);
  import rgbe_rle_pkg::*;

  localparam int unsigned AW = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
  localparam logic [CMP_W-1:0] MAX_LW = CMP_W'(MAX_LINE_WIDTH);

  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_HDR2    = 3'd2;
  localparam logic [2:0] PH_HDR3    = 3'd3;
  localparam logic [2:0] PH_COUNT   = 3'd4;
  localparam logic [2:0] PH_RUNVAL  = 3'd5;
  localparam logic [2:0] PH_LITERAL = 3'd6;

  localparam logic [1:0] SEQ_IDLE = 2'd0;
  localparam logic [1:0] SEQ_FILL = 2'd1;
  localparam logic [1:0] SEQ_READ = 2'd2;

  localparam logic [1:0] LAST_CHAN = 2'd3;

  logic [LW_W-1:0]   lw_q;
  logic [1:0]        seq_q, seq_d;
  logic [2:0]        phase_q, phase_d;
  logic [HDR_W-1:0]  hdr_q, hdr_d;
  logic [1:0]        chan_q, chan_d;
  logic [LW_W-1:0]   col_q, col_d;
  logic [BYTE_W-1:0] seg_q, seg_d;
  logic [BYTE_W-1:0] fill_val_q, fill_val_d;
  logic              in_rng_q, in_rng_d;
  logic              hold_vld_q, hold_vld_d;
  status_e           hold_st_q, hold_st_d;
  logic [WORD_W-1:0] hold_word_q, hold_word_d;
  logic              out_vld_q;
  status_e           out_st_q;
  logic [WORD_W-1:0] out_word_q;

  logic              accept;
  logic              out_load;
  logic              wr_en;
  logic [BYTE_W-1:0] wr_data;
  logic              rd_en;
  logic              res_vld;
  status_e           res_st;
  logic [WORD_W-1:0] res_word;
  logic              seg_end;
  logic [LW_W-1:0]   col_new;
  logic              restart;

  logic [CMP_W-1:0]  lw16, col16, idx16, hdr_w16;
  logic              width_ok, fits_run, fits_cnt, fits_one, rd_ok, magic_bad;
  logic [BYTE_W-1:0] in_byte;
  logic [BYTE_W-1:0] rd_data [4];

  assign in_byte   = req_i.stream_byte;
  assign lw16      = CMP_W'(lw_q);
  assign col16     = CMP_W'(col_q);
  assign idx16     = CMP_W'(req_i.pixel_index);
  assign hdr_w16   = CMP_W'({hdr_q[6:0], in_byte});
  assign width_ok  = (lw16 >= CMP_W'(MIN_LINE_WIDTH)) && (lw16 <= MAX_LW);
  assign fits_run  = width_ok && ((col16 + CMP_W'(seg_q)) <= lw16);
  assign fits_cnt  = width_ok && ((col16 + CMP_W'(in_byte)) <= lw16);
  assign fits_one  = width_ok && (col16 < lw16);
  assign rd_ok     = (idx16 < lw16) && (idx16 < MAX_LW);
  assign magic_bad = (hdr_q[23:16] != HDR_MAGIC) || (hdr_q[15:8] != HDR_MAGIC) || hdr_q[7];

  assign req_i.ready = (seq_q == SEQ_IDLE) && !hold_vld_q;
  assign accept      = req_i.valid && req_i.ready;
  assign cfg_i.ready = (seq_q == SEQ_IDLE);
  assign out_load    = hold_vld_q && (!out_vld_q || rsp_o.ready);

  always_comb begin
    seq_d      = seq_q;
    phase_d    = phase_q;
    hdr_d      = hdr_q;
    chan_d     = chan_q;
    col_d      = col_q;
    seg_d      = seg_q;
    fill_val_d = fill_val_q;
    in_rng_d   = in_rng_q;
    wr_en      = 1'b0;
    wr_data    = in_byte;
    rd_en      = 1'b0;
    res_vld    = 1'b0;
    res_st     = ST_DONE;
    res_word   = '0;
    seg_end    = 1'b0;
    col_new    = col_q + LW_W'(1);
    restart    = 1'b0;

    case (seq_q)
      SEQ_IDLE: begin
        if (accept) begin
          if (req_i.req_type) begin
            rd_en    = 1'b1;
            in_rng_d = rd_ok;
            seq_d    = SEQ_READ;
          end else begin
            case (phase_q)
              PH_HDR0, PH_HDR1, PH_HDR2: begin
                hdr_d   = {hdr_q[15:0], in_byte};
                phase_d = phase_q + 3'd1;
              end
              PH_HDR3: begin
                if (magic_bad) begin
                  restart = 1'b1;
                  res_vld = 1'b1;
                  res_st  = ST_BAD_HEADER;
                end else if (!width_ok || (hdr_w16 != lw16)) begin
                  restart = 1'b1;
                  res_vld = 1'b1;
                  res_st  = ST_WIDTH;
                end else begin
                  phase_d = PH_COUNT;
                  chan_d  = '0;
                  col_d   = '0;
                  seg_d   = '0;
                end
              end
              PH_COUNT: begin
                if (in_byte == '0) begin
                  restart = 1'b1;
                  res_vld = 1'b1;
                  res_st  = ST_ZERO;
                end else if (in_byte > RUN_BASE) begin
                  seg_d   = in_byte - RUN_BASE;
                  phase_d = PH_RUNVAL;
                end else if (!fits_cnt) begin
                  restart = 1'b1;
                  res_vld = 1'b1;
                  res_st  = ST_OVERRUN;
                end else begin
                  seg_d   = in_byte;
                  phase_d = PH_LITERAL;
                end
              end
              PH_RUNVAL: begin
                if (!fits_run) begin
                  restart = 1'b1;
                  res_vld = 1'b1;
                  res_st  = ST_OVERRUN;
                end else begin
                  fill_val_d = in_byte;
                  seq_d      = SEQ_FILL;
                end
              end
              PH_LITERAL: begin
                if (!fits_one) begin
                  restart = 1'b1;
                  res_vld = 1'b1;
                  res_st  = ST_OVERRUN;
                end else begin
                  wr_en = 1'b1;
                  col_d = col_new;
                  seg_d = seg_q - 8'd1;
                  if (seg_q == 8'd1) begin
                    seg_end = 1'b1;
                  end
                end
              end
              default: begin
                restart = 1'b1;
              end
            endcase
          end
        end
      end
      SEQ_FILL: begin
        wr_en   = 1'b1;
        wr_data = fill_val_q;
        col_d   = col_new;
        seg_d   = seg_q - 8'd1;
        if (seg_q == 8'd1) begin
          seq_d   = SEQ_IDLE;
          seg_end = 1'b1;
        end
      end
      SEQ_READ: begin
        res_vld  = 1'b1;
        res_st   = ST_READ;
        res_word = in_rng_q ? {rd_data[3], rd_data[2], rd_data[1], rd_data[0]} : '0;
        seq_d    = SEQ_IDLE;
      end
      default: begin
        seq_d = SEQ_IDLE;
      end
    endcase

    // closing a segment: next channel or end of line
    if (seg_end) begin
      phase_d = PH_COUNT;
      if (CMP_W'(col_new) == lw16) begin
        if (chan_q == LAST_CHAN) begin
          restart = 1'b1;
          res_vld = 1'b1;
          res_st  = ST_DONE;
        end else begin
          chan_d = chan_q + 2'd1;
          col_d  = '0;
        end
      end
    end

    if (restart) begin
      phase_d = PH_HDR0;
      hdr_d   = '0;
      chan_d  = '0;
      col_d   = '0;
      seg_d   = '0;
    end
  end

  always_comb begin
    hold_vld_d  = hold_vld_q;
    hold_st_d   = hold_st_q;
    hold_word_d = hold_word_q;
    if (res_vld) begin
      hold_vld_d  = 1'b1;
      hold_st_d   = res_st;
      hold_word_d = res_word;
    end else if (out_load) begin
      hold_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q       <= LW_RESET;
      seq_q      <= SEQ_IDLE;
      phase_q    <= PH_HDR0;
      hdr_q      <= '0;
      chan_q     <= '0;
      col_q      <= '0;
      seg_q      <= '0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        lw_q <= cfg_i.line_width;
      end
      seq_q      <= seq_d;
      phase_q    <= phase_d;
      hdr_q      <= hdr_d;
      chan_q     <= chan_d;
      col_q      <= col_d;
      seg_q      <= seg_d;
      hold_vld_q <= hold_vld_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fill_val_q  <= fill_val_d;
    in_rng_q    <= in_rng_d;
    hold_st_q   <= hold_st_d;
    hold_word_q <= hold_word_d;
    if (out_load) begin
      out_st_q   <= hold_st_q;
      out_word_q <= hold_word_q;
    end
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.status     = out_st_q;
  assign rsp_o.pixel_word = out_word_q;

  // one bank per channel, read together for an interleaved pixel
  for (genvar g = 0; g < 4; g++) begin : g_bank
    rgbe_rle_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_LINE_WIDTH)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (wr_en && (chan_q == 2'(g))),
      .waddr_i (AW'(col_q)),
      .wdata_i (wr_data),
      .re_i    (rd_en),
      .raddr_i (AW'(req_i.pixel_index)),
      .rdata_o (rd_data[g])
    );
  end

  a_write_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (col16 < lw16))
    else $error("line store write beyond line width");

  a_fill_context: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SEQ_FILL) |-> ((phase_q == PH_RUNVAL) && (seg_q != '0)))
    else $error("run fill outside a run segment");

  a_read_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.req_type) |=> ((seq_q == SEQ_READ) && !hold_vld_q))
    else $error("read transaction not followed by read cycle");

  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SEQ_READ) |=> (hold_vld_q && (hold_st_q == ST_READ)))
    else $error("read data not held for response");

  a_hold_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_vld_q && !out_load) |=> hold_vld_q && $stable(hold_word_q))
    else $error("held result lost before output load");

endmodule

// File: tb/tb_rgbe_scanline_rle_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgbe_scanline_rle_decoder_top
// Self-checking testbench for the RGBE run-length scanline decoder. A shadow
// decoder tracks header, channel and segment state and the line store, and
// works out the status or pixel word owed for each accepted transaction.
// Directed tests cover header faults, segment faults, line width register
// extremes and rewrites within a line, and the widest line; random lines with
// noise, corrupted headers and pixel reads follow, under random sender gaps
// and receiver stalls.
// ----------------------------------------------------------------------------
module tb_rgbe_scanline_rle_decoder_top;
  import rgbe_rle_pkg::*;

  localparam int unsigned MAX_W         = DEF_MAX_LINE_WIDTH;
  localparam int unsigned SETTLE_CYCLES = 160;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned TOTAL_ITEMS   = 1250;
  localparam logic        REQ_PUSH      = 1'b0;
  localparam logic        REQ_READ      = 1'b1;
  localparam logic [7:0]  ZERO_COUNT    = 8'h00;

  typedef enum logic [2:0] {
    HDR_B0, HDR_B1, HDR_B2, HDR_B3, SEG_COUNT, RUN_VALUE, LIT_BYTES
  } scan_phase_e;

  typedef struct packed {
    status_e           status;
    logic [WORD_W-1:0] word;
  } decode_rsp_t;

  logic clk_i;
  logic rst_ni;

  rgbe_rle_req_if req_if ();
  rgbe_rle_rsp_if rsp_if ();
  rgbe_rle_cfg_if cfg_if ();

  rgbe_scanline_rle_decoder_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // shadow decoder state
  logic [BYTE_W-1:0] line_mem [0:4*MAX_W-1];
  bit                line_set [0:4*MAX_W-1];
  logic [LW_W-1:0]   sh_width;
  scan_phase_e       sh_phase;
  logic [HDR_W-1:0]  sh_hdr;
  logic [1:0]        sh_chan;
  int unsigned       sh_col;
  int unsigned       sh_left;

  decode_rsp_t owed_rsp [$];
  int          fail_count  = 0;
  int          items_sent  = 0;
  int          burst_left  = 0;
  int          quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- shadow model

  function automatic bit width_ok();
    return sh_width >= MIN_LINE_WIDTH && sh_width <= MAX_W;
  endfunction

  function automatic bit seg_fits(int unsigned len);
    return width_ok() && sh_col + len <= sh_width;
  endfunction

  function automatic void rearm_header();
    sh_phase = HDR_B0;
    sh_hdr   = '0;
    sh_chan  = '0;
    sh_col   = 0;
    sh_left  = 0;
  endfunction

  function automatic void owe(status_e st, logic [WORD_W-1:0] w);
    decode_rsp_t r;
    r.status = st;
    r.word   = w;
    owed_rsp.push_back(r);
  endfunction

  function automatic void fault(status_e st);
    rearm_header();
    owe(st, '0);
  endfunction

  function automatic void store_byte(int unsigned col, logic [7:0] v);
    int unsigned a;
    a = sh_chan * MAX_W + col;
    if (a < 4 * MAX_W) begin
      line_mem[a] = v;
      line_set[a] = 1'b1;
    end
  endfunction

  function automatic bit close_segment();
    sh_phase = SEG_COUNT;
    if (sh_col == sh_width) begin
      if (sh_chan == 2'd3) begin
        rearm_header();
        return 1'b1;
      end
      sh_chan = sh_chan + 2'd1;
      sh_col  = 0;
    end
    return 1'b0;
  endfunction

  function automatic void track_push(logic [7:0] b);
    int unsigned i;
    case (sh_phase)
      HDR_B0: begin
        sh_hdr   = {sh_hdr[15:0], b};
        sh_phase = HDR_B1;
      end
      HDR_B1: begin
        sh_hdr   = {sh_hdr[15:0], b};
        sh_phase = HDR_B2;
      end
      HDR_B2: begin
        sh_hdr   = {sh_hdr[15:0], b};
        sh_phase = HDR_B3;
      end
      HDR_B3: begin
        if (sh_hdr[23:16] != HDR_MAGIC || sh_hdr[15:8] != HDR_MAGIC || sh_hdr[7]) begin
          fault(ST_BAD_HEADER);
        end else if (!width_ok() || {sh_hdr[6:0], b} != sh_width) begin
          fault(ST_WIDTH);
        end else begin
          sh_phase = SEG_COUNT;
          sh_chan  = '0;
          sh_col   = 0;
          sh_left  = 0;
        end
      end
      SEG_COUNT: begin
        if (b == ZERO_COUNT) begin
          fault(ST_ZERO);
        end else if (b > RUN_BASE) begin
          sh_left  = b - RUN_BASE;
          sh_phase = RUN_VALUE;
        end else if (!seg_fits(b)) begin
          fault(ST_OVERRUN);
        end else begin
          sh_left  = b;
          sh_phase = LIT_BYTES;
        end
      end
      RUN_VALUE: begin
        if (!seg_fits(sh_left)) begin
          fault(ST_OVERRUN);
        end else begin
          for (i = 0; i < sh_left; i++) store_byte(sh_col + i, b);
          sh_col  = sh_col + sh_left;
          sh_left = 0;
          if (close_segment()) owe(ST_DONE, '0);
        end
      end
      LIT_BYTES: begin
        if (!seg_fits(1)) begin
          fault(ST_OVERRUN);
        end else begin
          store_byte(sh_col, b);
          sh_col  = sh_col + 1;
          sh_left = sh_left - 1;
          if (sh_left == 0 && close_segment()) owe(ST_DONE, '0);
        end
      end
      default: rearm_header();
    endcase
  endfunction

  function automatic void track_read(int unsigned idx);
    logic [WORD_W-1:0] w;
    int unsigned c;
    w = '0;
    if (idx < sh_width && idx < MAX_W) begin
      for (c = 0; c < 4; c++) w[8*c +: 8] = line_mem[c * MAX_W + idx];
    end
    owe(ST_READ, w);
  endfunction

  function automatic bit can_read(int unsigned idx);
    if (idx >= sh_width || idx >= MAX_W) return 1'b1;
    return line_set[idx] && line_set[MAX_W + idx] && line_set[2*MAX_W + idx] &&
           line_set[3*MAX_W + idx];
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_item(logic rt, logic [7:0] b, logic [IDX_W-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_if.valid       <= 1'b1;
    req_if.req_type    <= rt;
    req_if.stream_byte <= b;
    req_if.pixel_index <= idx;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    items_sent++;
    if (rt == REQ_READ) track_read(idx);
    else track_push(b);
  endtask

  task automatic feed_byte(logic [7:0] b);
    send_item(REQ_PUSH, b, $urandom_range(0, MAX_W - 1));
  endtask

  task automatic read_pixel(int unsigned idx);
    send_item(REQ_READ, $urandom_range(0, 255), idx);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (owed_rsp.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_line_width(logic [LW_W-1:0] v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_if.valid      <= 1'b1;
    cfg_if.line_width <= v;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    sh_width = v;
  endtask

  task automatic push_header(logic [14:0] w);
    feed_byte(HDR_MAGIC);
    feed_byte(HDR_MAGIC);
    feed_byte({1'b0, w[14:8]});
    feed_byte(w[7:0]);
  endtask

  task automatic random_read();
    int unsigned lim, idx;
    lim = (sh_width < MAX_W) ? sh_width : MAX_W;
    repeat (8) begin
      idx = (lim != 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, lim - 1)
                                                    : $urandom_range(0, MAX_W - 1);
      if (can_read(idx)) begin
        read_pixel(idx);
        return;
      end
    end
    if (sh_width < MAX_W) read_pixel($urandom_range(sh_width, MAX_W - 1));
  endtask

  // drives segments from the shadow state until the line ends or fails
  task automatic finish_line(int noise_pct, bit long_runs);
    int unsigned room, maxl, len;
    while (sh_phase != HDR_B0) begin
      if ($urandom_range(0, 99) < 8) random_read();
      room = (width_ok() && sh_col < sh_width) ? sh_width - sh_col : 0;
      if ($urandom_range(0, 99) < noise_pct || room == 0 || sh_phase != SEG_COUNT) begin
        feed_byte($urandom_range(0, 255));
      end else if (long_runs) begin
        len = (room < 127) ? room : 127;
        feed_byte(RUN_BASE + len);
      end else if ($urandom_range(0, 1) == 1) begin
        maxl = (room < 127) ? room : 127;
        len  = ($urandom_range(0, 3) == 0) ? maxl : $urandom_range(1, maxl);
        feed_byte(RUN_BASE + len);
      end else begin
        maxl = (room < 128) ? room : 128;
        len  = ($urandom_range(0, 3) == 0) ? maxl : $urandom_range(1, maxl);
        feed_byte(len);
      end
    end
  endtask

  task automatic decode_line(int unsigned w, int noise_pct, bit long_runs);
    push_header(w);
    finish_line(noise_pct, long_runs);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_basic_line();
    int unsigned c;
    write_line_width(MIN_LINE_WIDTH);
    read_pixel(MAX_W - 1);
    push_header(MIN_LINE_WIDTH);
    for (c = 0; c < 4; c++) begin
      feed_byte(RUN_BASE + MIN_LINE_WIDTH);
      feed_byte($urandom_range(0, 255));
    end
    read_pixel(0);
    read_pixel(MIN_LINE_WIDTH - 1);
    decode_line(MIN_LINE_WIDTH, 0, 1'b0);
    random_read();
  endtask

  task automatic test_header_faults();
    feed_byte(8'h00);
    feed_byte(HDR_MAGIC);
    feed_byte(8'h00);
    feed_byte(MIN_LINE_WIDTH);
    feed_byte(HDR_MAGIC);
    feed_byte(HDR_MAGIC);
    feed_byte(8'h80);
    feed_byte(MIN_LINE_WIDTH);
    push_header(MIN_LINE_WIDTH + 1);
  endtask

  task automatic test_segment_faults();
    int unsigned i;
    push_header(MIN_LINE_WIDTH);
    feed_byte(ZERO_COUNT);
    push_header(MIN_LINE_WIDTH);
    feed_byte(RUN_BASE);
    push_header(MIN_LINE_WIDTH);
    feed_byte(8'hFF);
    feed_byte($urandom_range(0, 255));
    push_header(MIN_LINE_WIDTH);
    feed_byte(5);
    for (i = 0; i < 5; i++) feed_byte($urandom_range(0, 255));
    feed_byte(4);
  endtask

  task automatic test_width_register();
    logic [LW_W-1:0] bad_widths [4];
    int unsigned i;
    bad_widths = '{14'd0, 14'd7, 14'd8193, 14'd16383};
    foreach (bad_widths[k]) begin
      write_line_width(bad_widths[k]);
      push_header(bad_widths[k]);
    end
    // rewrite to out of range within a line, literal then run
    write_line_width(16);
    push_header(16);
    feed_byte(4);
    for (i = 0; i < 4; i++) feed_byte($urandom_range(0, 255));
    write_line_width(8193);
    feed_byte(2);
    write_line_width(16);
    push_header(16);
    feed_byte(4);
    for (i = 0; i < 4; i++) feed_byte($urandom_range(0, 255));
    write_line_width(14'd16383);
    feed_byte(RUN_BASE + 2);
    feed_byte($urandom_range(0, 255));
    // shrink below the current column
    write_line_width(16);
    push_header(16);
    feed_byte(RUN_BASE + 10);
    feed_byte($urandom_range(0, 255));
    write_line_width(MIN_LINE_WIDTH);
    feed_byte(1);
    // shrink so that the next run closes the channel
    write_line_width(16);
    push_header(16);
    feed_byte(RUN_BASE + 4);
    feed_byte($urandom_range(0, 255));
    write_line_width(12);
    feed_byte(RUN_BASE + 8);
    feed_byte($urandom_range(0, 255));
    finish_line(0, 1'b0);
  endtask

  task automatic test_widest_line();
    write_line_width(MAX_W);
    decode_line(MAX_W, 0, 1'b1);
    read_pixel(0);
    read_pixel(MAX_W - 1);
    repeat (4) random_read();
  endtask

  task automatic test_random_lines();
    int          line_no, r, p;
    int unsigned cur_w;
    logic [7:0]  hb [4];
    logic [LW_W-1:0] bad_w;
    line_no = 0;
    cur_w   = MIN_LINE_WIDTH;
    while (items_sent < TOTAL_ITEMS) begin
      if (line_no % 5 == 0) begin
        cur_w = ($urandom_range(0, 99) < 85) ? $urandom_range(8, 40) : $urandom_range(41, 300);
        write_line_width(cur_w);
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        hb[0] = HDR_MAGIC;
        hb[1] = HDR_MAGIC;
        hb[2] = cur_w[15:8];
        hb[3] = cur_w[7:0];
        p = $urandom_range(0, 3);
        hb[p] = $urandom_range(0, 255);
        foreach (hb[k]) feed_byte(hb[k]);
        if (sh_phase != HDR_B0) finish_line(0, 1'b0);
      end else if (r < 12) begin
        bad_w = ($urandom_range(0, 1) == 1) ? $urandom_range(0, MIN_LINE_WIDTH - 1)
                                            : $urandom_range(MAX_W + 1, 16383);
        write_line_width(bad_w);
        push_header(bad_w);
        write_line_width(cur_w);
      end else begin
        decode_line(cur_w, ($urandom_range(0, 9) < 3) ? 2 : 0, 1'b0);
      end
      if ($urandom_range(0, 9) == 0) wait_drained();
      repeat ($urandom_range(0, 2)) random_read();
      line_no++;
    end
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin
    int mode, mode_left, stall_left;
    mode       = 0;
    mode_left  = 0;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        0: rsp_if.ready <= 1'b1;
        1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
        2: rsp_if.ready <= ($urandom_range(0, 1) != 0);
        default: begin
          if (stall_left != 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
          end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(4, 24);
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- checking

  always @(posedge clk_i) begin
    decode_rsp_t head;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (owed_rsp.size() == 0) begin
        $error("response transaction with nothing outstanding: status %0d", rsp_if.status);
        fail_count++;
      end else begin
        head = owed_rsp.pop_front();
        if (rsp_if.status !== head.status) begin
          $error("status: expected %0d, got %0d", head.status, rsp_if.status);
          fail_count++;
        end
        if (rsp_if.pixel_word !== head.word) begin
          $error("pixel_word: expected %08h, got %08h", head.word, rsp_if.pixel_word);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) ||
        (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("rgbe_scanline_rle_decoder_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    req_if.valid       <= 1'b0;
    req_if.req_type    <= REQ_PUSH;
    req_if.stream_byte <= '0;
    req_if.pixel_index <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.line_width  <= LW_RESET;
    rst_ni             <= 1'b0;
    sh_width = LW_RESET;
    rearm_header();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_line();
    test_header_faults();
    test_segment_faults();
    test_width_register();
    test_widest_line();
    test_random_lines();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && owed_rsp.size() == 0) begin
      $display("rgbe_scanline_rle_decoder_top regression: pass");
    end else begin
      $display("rgbe_scanline_rle_decoder_top regression: fail");
    end
    $finish;
  end

endmodule

// File: rgbe_scanline_rle_decoder_top.f
rtl/rgbe_rle_pkg.sv
rtl/rgbe_rle_if.sv
rtl/rgbe_rle_ram.sv
rtl/rgbe_scanline_rle_decoder_top.sv
tb/tb_rgbe_scanline_rle_decoder_top.sv
